// ===== rtl/bitmap_rle_decoder_top_assert.svh =====
// Assertion macros for the bitmap RLE decoder checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef BITMAP_RLE_DECODER_TOP_ASSERT_SVH
`define BITMAP_RLE_DECODER_TOP_ASSERT_SVH

// Plain property, clocked on clk_i, off during reset.
`define BRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define BRD_ASSERT_NEXT(label, pre, post, msg) \
  `BRD_ASSERT(label, (pre) |=> (post), msg)

`endif

// ===== rtl/brd_pkg.sv =====
// Shared types and constants of the bitmap RLE decoder.
// Used by the RTL files of the block except brd_div; depends on nothing.
package brd_pkg;

  localparam int CODE_W  = 8;
  localparam int CFG_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 2;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CIDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IDX_FOUR   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_SPAN = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EOB  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERR  = 2'd2;

  localparam logic [CODE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [CODE_W-1:0] ESC_EOB   = 8'd1;
  localparam logic [CODE_W-1:0] ESC_DELTA = 8'd2;

  typedef enum logic [3:0] {
    PH_FIRST     = 4'd0,
    PH_ESCAPE    = 4'd1,
    PH_RUN_VALUE = 4'd2,
    PH_DELTA_X   = 4'd3,
    PH_DELTA_Y   = 4'd4,
    PH_ABSOLUTE  = 4'd5,
    PH_PAD       = 4'd6,
    PH_DONE      = 4'd7,
    PH_ERROR     = 4'd8
  } phase_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_DELTA,
    SQ_DIVA_GO,
    SQ_DIVA_WAIT,
    SQ_DIVB_GO,
    SQ_DIVB_WAIT,
    SQ_SPAN,
    SQ_SETTLE
  } seq_e;

  typedef enum logic [1:0] {
    RES_EOB,
    RES_ERR,
    RES_RUN,
    RES_ABS
  } res_e;

  typedef struct packed {
    logic load;
    logic pend_load;
    logic dx_load;
    logic jump_load;
    logic delta_apply;
    logic eol;
    logic abs_load;
    logic pad_clear;
    logic div_start;
    logic div_hi;
    logic col_load;
    logic row_adv;
    logic cnt_pend;
    logic emit;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic code_zero;
    logic code_one;
    logic code_two;
    logic ov_code;
    logic ov_pend;
    logic pos_ge_size;
    logic abs_last;
    logic pad_set;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/brd_div.sv =====
// Bit-serial remainder unit: one dividend bit per cycle.
// Standalone; used by brd_datapath for the row-end update.
module brd_div #(
  parameter int DW = 26,
  parameter int VW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [VW-1:0] dvs_q;
  logic [VW-1:0] rem_q;
  logic [VW:0]   partial;
  logic [VW:0]   diff;
  logic [VW-1:0] rem_step;

  assign partial  = {rem_q, dvd_q[DW-1]};
  assign diff     = partial - {1'b0, dvs_q};
  assign rem_step = (partial >= {1'b0, dvs_q}) ? diff[VW-1:0] : partial[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/brd_datapath.sv =====
// Datapath: configuration, position and row-end registers, result register.
// Depends on brd_pkg and brd_div; driven by brd_ctrl commands.
module brd_datapath #(
  parameter int MAX_WIDTH  = brd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = brd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [brd_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [brd_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [brd_pkg::CODE_W-1:0]  code_byte_i,
  input  logic                        frame_start_i,
  input  brd_pkg::cmd_t               cmd_i,
  output brd_pkg::sts_t               sts_o,
  output logic [brd_pkg::ADDR_W-1:0]  write_address_o,
  output logic [brd_pkg::CODE_W-1:0]  pixel_count_o,
  output logic [brd_pkg::CODE_W-1:0]  even_value_o,
  output logic [brd_pkg::CODE_W-1:0]  odd_value_o,
  output logic [brd_pkg::STAT_W-1:0]  status_o
);

  localparam int     CFG_MAX = (1 << brd_pkg::CFG_W) - 1;
  localparam int     WMAX    = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
  localparam int     HMAX    = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
  localparam int     WW      = $clog2(WMAX + 1);
  localparam int     HW      = $clog2(HMAX + 1);
  localparam longint SMAX    = longint'(WMAX) * longint'(HMAX);
  localparam int     SW      = $clog2(SMAX + 1);
  localparam longint PMAX    = SMAX + 260 * longint'(WMAX) + 1024;
  localparam int     PW      = $clog2(PMAX + 1) + 1;
  localparam int     JW      = brd_pkg::CODE_W + WW;
  localparam int     CW      = brd_pkg::CODE_W;

  logic [brd_pkg::CFG_W-1:0] cfg_w_q;
  logic [brd_pkg::CFG_W-1:0] cfg_h_q;
  logic                      four_q;
  logic [SW-1:0]             size_q;
  logic [PW-1:0]             pos_q;
  logic [PW-1:0]             row_end_q;
  logic [CW-1:0]             abs_rem_q;
  logic [CW-1:0]             pend_q;
  logic [CW-1:0]             dx_q;
  logic                      pad_q;
  logic [CW-1:0]             code_q;
  logic [JW-1:0]             jump_q;
  logic [WW-1:0]             col_q;

  logic [brd_pkg::ADDR_W-1:0] addr_q;
  logic [CW-1:0]              cnt_out_q;
  logic [CW-1:0]              ev_q;
  logic [CW-1:0]              od_q;
  logic [brd_pkg::STAT_W-1:0] stat_q;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [WW+HW-1:0] size_prod;
  logic [PW:0]      pos_x;
  logic [PW:0]      size_x;
  logic [CW-1:0]    cnt_sel;
  logic [PW-1:0]    dividend;
  logic             div_done;
  logic [WW-1:0]    div_rem;
  logic [CW-1:0]    abs_n_pre;
  logic [CW-1:0]    abs_n;
  logic [CW-1:0]    ev_run;
  logic [CW-1:0]    od_run;
  logic [CW-1:0]    ev_abs;
  logic [CW-1:0]    od_abs;
  logic [CW:0]      code_p1;
  logic             pad_new;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > 32'(WMAX)) begin
      w_eff = WW'(WMAX);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_q) > 32'(HMAX)) begin
      h_eff = HW'(HMAX);
    end else begin
      h_eff = HW'(cfg_h_q);
    end
  end

  assign size_prod = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);

  assign pos_x  = {1'b0, pos_q};
  assign size_x = (PW+1)'(size_q);

  assign cnt_sel  = cmd_i.cnt_pend ? pend_q : code_q;
  assign dividend = cmd_i.div_hi ? (pos_q + PW'(cnt_sel)) : pos_q;

  brd_div #(
    .DW(PW),
    .VW(WW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (w_eff),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    if (four_q && (abs_rem_q >= CW'(2))) begin
      abs_n_pre = CW'(2);
    end else begin
      abs_n_pre = CW'(1);
    end
    abs_n  = (abs_n_pre > abs_rem_q) ? abs_rem_q : abs_n_pre;
    ev_abs = four_q ? {4'b0, code_q[7:4]} : code_q;
    od_abs = (four_q && (abs_n_pre == CW'(2))) ? {4'b0, code_q[3:0]} : '0;
    ev_run = four_q ? {4'b0, code_q[7:4]} : code_q;
    od_run = four_q ? {4'b0, code_q[3:0]} : code_q;
    if (pend_q < CW'(2)) begin
      od_run = '0;
    end
  end

  assign code_p1 = {1'b0, code_q} + (CW+1)'(1);
  assign pad_new = four_q ? code_p1[1] : code_q[0];

  always_comb begin
    sts_o             = '0;
    sts_o.code_zero   = (code_q == brd_pkg::ESC_EOL);
    sts_o.code_one    = (code_q == brd_pkg::ESC_EOB);
    sts_o.code_two    = (code_q == brd_pkg::ESC_DELTA);
    sts_o.ov_code     = (pos_x >= size_x) || ((pos_x + (PW+1)'(code_q)) > size_x);
    sts_o.ov_pend     = (pos_x >= size_x) || ((pos_x + (PW+1)'(pend_q)) > size_x);
    sts_o.pos_ge_size = (pos_x >= size_x);
    sts_o.abs_last    = (abs_rem_q == abs_n);
    sts_o.pad_set     = pad_q;
    sts_o.div_done    = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= brd_pkg::CFG_W'(1);
      cfg_h_q <= brd_pkg::CFG_W'(1);
      four_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brd_pkg::CFG_IDX_WIDTH:  cfg_w_q <= cfg_data_i;
        brd_pkg::CFG_IDX_HEIGHT: cfg_h_q <= cfg_data_i;
        brd_pkg::CFG_IDX_FOUR:   four_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SW'(1);
      pos_q     <= '0;
      row_end_q <= PW'(1);
      abs_rem_q <= '0;
      pend_q    <= '0;
      dx_q      <= '0;
      pad_q     <= 1'b0;
    end else begin
      size_q <= SW'(size_prod);
      if (cmd_i.load) begin
        if (frame_start_i) begin
          pos_q     <= '0;
          row_end_q <= PW'(w_eff);
          abs_rem_q <= '0;
          pend_q    <= '0;
          dx_q      <= '0;
          pad_q     <= 1'b0;
        end
      end else if (cmd_i.pend_load) begin
        pend_q <= code_q;
      end else if (cmd_i.dx_load) begin
        dx_q <= code_q;
      end else if (cmd_i.delta_apply) begin
        pos_q     <= pos_q + PW'(jump_q) + PW'(dx_q);
        row_end_q <= row_end_q + PW'(jump_q);
      end else if (cmd_i.eol) begin
        pos_q     <= row_end_q;
        row_end_q <= row_end_q + PW'(w_eff);
      end else if (cmd_i.abs_load) begin
        abs_rem_q <= code_q;
        pad_q     <= pad_new;
      end else if (cmd_i.pad_clear) begin
        pad_q <= 1'b0;
      end else if (cmd_i.row_adv) begin
        row_end_q <= row_end_q + PW'(col_q) + PW'(cnt_sel) - PW'(div_rem);
      end else if (cmd_i.emit) begin
        if (cmd_i.res_sel == brd_pkg::RES_RUN) begin
          pos_q <= pos_q + PW'(pend_q);
        end else if (cmd_i.res_sel == brd_pkg::RES_ABS) begin
          pos_q     <= pos_q + PW'(abs_n);
          abs_rem_q <= abs_rem_q - abs_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= code_byte_i;
    end
    if (cmd_i.jump_load) begin
      jump_q <= JW'(code_q) * JW'(w_eff);
    end
    if (cmd_i.col_load) begin
      col_q <= div_rem;
    end
    if (cmd_i.emit) begin
      unique case (cmd_i.res_sel)
        brd_pkg::RES_EOB: begin
          addr_q    <= '0;
          cnt_out_q <= '0;
          ev_q      <= '0;
          od_q      <= '0;
          stat_q    <= brd_pkg::STAT_EOB;
        end
        brd_pkg::RES_ERR: begin
          addr_q    <= '0;
          cnt_out_q <= '0;
          ev_q      <= '0;
          od_q      <= '0;
          stat_q    <= brd_pkg::STAT_ERR;
        end
        brd_pkg::RES_RUN: begin
          addr_q    <= brd_pkg::ADDR_W'(pos_q);
          cnt_out_q <= pend_q;
          ev_q      <= ev_run;
          od_q      <= od_run;
          stat_q    <= brd_pkg::STAT_SPAN;
        end
        brd_pkg::RES_ABS: begin
          addr_q    <= brd_pkg::ADDR_W'(pos_q);
          cnt_out_q <= abs_n;
          ev_q      <= ev_abs;
          od_q      <= od_abs;
          stat_q    <= brd_pkg::STAT_SPAN;
        end
        default: ;
      endcase
    end
  end

  assign write_address_o = addr_q;
  assign pixel_count_o   = cnt_out_q;
  assign even_value_o    = ev_q;
  assign odd_value_o     = od_q;
  assign status_o        = stat_q;

endmodule

// ===== rtl/brd_ctrl.sv =====
// Controller: parse phase and operation sequencer of the decoder.
// Depends on brd_pkg; issues commands to brd_datapath.
module brd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_frame_start_i,
  input  logic          out_stall_i,
  input  brd_pkg::sts_t sts_i,
  output brd_pkg::cmd_t cmd_o,
  output logic          in_stall_o,
  output logic          out_valid_o
);

  brd_pkg::seq_e   state_q, state_d;
  brd_pkg::phase_e phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      brd_pkg::SQ_IDLE: begin
        if (in_valid_i) begin
          state_d = brd_pkg::SQ_EXEC;
          if (in_frame_start_i) begin
            phase_d = brd_pkg::PH_FIRST;
          end
        end
      end
      brd_pkg::SQ_EXEC: begin
        unique case (phase_q)
          brd_pkg::PH_FIRST: begin
            phase_d = sts_i.code_zero ? brd_pkg::PH_ESCAPE : brd_pkg::PH_RUN_VALUE;
            state_d = brd_pkg::SQ_IDLE;
          end
          brd_pkg::PH_ESCAPE: begin
            if (sts_i.code_zero) begin
              state_d = brd_pkg::SQ_SETTLE;
            end else if (sts_i.code_one) begin
              if (out_free) begin
                phase_d = brd_pkg::PH_DONE;
                state_d = brd_pkg::SQ_IDLE;
              end
            end else if (sts_i.code_two) begin
              phase_d = brd_pkg::PH_DELTA_X;
              state_d = brd_pkg::SQ_IDLE;
            end else if (sts_i.ov_code) begin
              if (out_free) begin
                phase_d = brd_pkg::PH_ERROR;
                state_d = brd_pkg::SQ_IDLE;
              end
            end else begin
              phase_d = brd_pkg::PH_ABSOLUTE;
              state_d = brd_pkg::SQ_DIVA_GO;
            end
          end
          brd_pkg::PH_RUN_VALUE: begin
            if (sts_i.ov_pend) begin
              if (out_free) begin
                phase_d = brd_pkg::PH_ERROR;
                state_d = brd_pkg::SQ_IDLE;
              end
            end else begin
              state_d = brd_pkg::SQ_DIVA_GO;
            end
          end
          brd_pkg::PH_DELTA_X: begin
            phase_d = brd_pkg::PH_DELTA_Y;
            state_d = brd_pkg::SQ_IDLE;
          end
          brd_pkg::PH_DELTA_Y: state_d = brd_pkg::SQ_DELTA;
          brd_pkg::PH_ABSOLUTE: begin
            if (out_free) begin
              if (!sts_i.abs_last) begin
                state_d = brd_pkg::SQ_IDLE;
              end else if (sts_i.pad_set) begin
                phase_d = brd_pkg::PH_PAD;
                state_d = brd_pkg::SQ_IDLE;
              end else begin
                state_d = brd_pkg::SQ_SETTLE;
              end
            end
          end
          brd_pkg::PH_PAD: state_d = brd_pkg::SQ_SETTLE;
          brd_pkg::PH_ERROR: begin
            if (out_free) begin
              state_d = brd_pkg::SQ_IDLE;
            end
          end
          default: state_d = brd_pkg::SQ_IDLE;
        endcase
      end
      brd_pkg::SQ_DELTA:   state_d = brd_pkg::SQ_SETTLE;
      brd_pkg::SQ_DIVA_GO: state_d = brd_pkg::SQ_DIVA_WAIT;
      brd_pkg::SQ_DIVA_WAIT: begin
        if (sts_i.div_done) begin
          state_d = brd_pkg::SQ_DIVB_GO;
        end
      end
      brd_pkg::SQ_DIVB_GO: state_d = brd_pkg::SQ_DIVB_WAIT;
      brd_pkg::SQ_DIVB_WAIT: begin
        if (sts_i.div_done) begin
          state_d = (phase_q == brd_pkg::PH_RUN_VALUE) ? brd_pkg::SQ_SPAN : brd_pkg::SQ_IDLE;
        end
      end
      brd_pkg::SQ_SPAN: begin
        if (out_free) begin
          state_d = brd_pkg::SQ_SETTLE;
        end
      end
      brd_pkg::SQ_SETTLE: begin
        phase_d = sts_i.pos_ge_size ? brd_pkg::PH_DONE : brd_pkg::PH_FIRST;
        state_d = brd_pkg::SQ_IDLE;
      end
      default: state_d = brd_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_sel  = brd_pkg::RES_EOB;
    cmd_o.cnt_pend = (phase_q == brd_pkg::PH_RUN_VALUE);
    unique case (state_q)
      brd_pkg::SQ_IDLE: cmd_o.load = in_valid_i;
      brd_pkg::SQ_EXEC: begin
        unique case (phase_q)
          brd_pkg::PH_FIRST: cmd_o.pend_load = !sts_i.code_zero;
          brd_pkg::PH_ESCAPE: begin
            if (sts_i.code_zero) begin
              cmd_o.eol = 1'b1;
            end else if (sts_i.code_one) begin
              cmd_o.emit    = out_free;
              cmd_o.res_sel = brd_pkg::RES_EOB;
            end else if (sts_i.code_two) begin
              cmd_o.emit = 1'b0;
            end else if (sts_i.ov_code) begin
              cmd_o.emit    = out_free;
              cmd_o.res_sel = brd_pkg::RES_ERR;
            end else begin
              cmd_o.abs_load = 1'b1;
            end
          end
          brd_pkg::PH_RUN_VALUE: begin
            cmd_o.emit    = sts_i.ov_pend && out_free;
            cmd_o.res_sel = brd_pkg::RES_ERR;
          end
          brd_pkg::PH_DELTA_X: cmd_o.dx_load = 1'b1;
          brd_pkg::PH_DELTA_Y: cmd_o.jump_load = 1'b1;
          brd_pkg::PH_ABSOLUTE: begin
            cmd_o.emit    = out_free;
            cmd_o.res_sel = brd_pkg::RES_ABS;
          end
          brd_pkg::PH_PAD: cmd_o.pad_clear = 1'b1;
          brd_pkg::PH_ERROR: begin
            cmd_o.emit    = out_free;
            cmd_o.res_sel = brd_pkg::RES_ERR;
          end
          default: ;
        endcase
      end
      brd_pkg::SQ_DELTA:     cmd_o.delta_apply = 1'b1;
      brd_pkg::SQ_DIVA_GO:   cmd_o.div_start = 1'b1;
      brd_pkg::SQ_DIVA_WAIT: cmd_o.col_load = sts_i.div_done;
      brd_pkg::SQ_DIVB_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_hi    = 1'b1;
      end
      brd_pkg::SQ_DIVB_WAIT: cmd_o.row_adv = sts_i.div_done;
      brd_pkg::SQ_SPAN: begin
        cmd_o.emit    = out_free;
        cmd_o.res_sel = brd_pkg::RES_RUN;
      end
      brd_pkg::SQ_SETTLE: ;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brd_pkg::SQ_IDLE;
      phase_q     <= brd_pkg::PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != brd_pkg::SQ_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/bitmap_rle_decoder_top.sv =====
// A run-value byte or absolute-run header takes two serial remainder passes over a
// PW-bit dividend (PW = 26 at default limits).
// Input: a new code byte is taken only once the last one is finished; a result waits in the output register.
// Reset: asynchronous, active low; width and height 1, RLE8, parser expects a code byte.
module bitmap_rle_decoder_top #(
  parameter int MAX_WIDTH  = brd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = brd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brd_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [brd_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [brd_pkg::CODE_W-1:0] code_byte_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [brd_pkg::ADDR_W-1:0] write_address_o,
  output logic [brd_pkg::CODE_W-1:0] pixel_count_o,
  output logic [brd_pkg::CODE_W-1:0] even_value_o,
  output logic [brd_pkg::CODE_W-1:0] odd_value_o,
  output logic [brd_pkg::STAT_W-1:0] status_o
);

  brd_pkg::cmd_t cmd;
  brd_pkg::sts_t sts;

  brd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_frame_start_i(frame_start_i),
    .out_stall_i     (out_stall_i),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o)
  );

  brd_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .code_byte_i    (code_byte_i),
    .frame_start_i  (frame_start_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .write_address_o(write_address_o),
    .pixel_count_o  (pixel_count_o),
    .even_value_o   (even_value_o),
    .odd_value_o    (odd_value_o),
    .status_o       (status_o)
  );

endmodule

// ===== rtl/brd_checker.sv =====
// Port-level checker for bitmap_rle_decoder_top, attached by bind.
// Depends on brd_pkg and bitmap_rle_decoder_top_assert.svh.
`include "bitmap_rle_decoder_top_assert.svh"

module brd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [brd_pkg::ADDR_W-1:0] write_address_o,
  input logic [brd_pkg::CODE_W-1:0] pixel_count_o,
  input logic [brd_pkg::CODE_W-1:0] even_value_o,
  input logic [brd_pkg::CODE_W-1:0] odd_value_o,
  input logic [brd_pkg::STAT_W-1:0] status_o
);

  `BRD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(write_address_o) && $stable(pixel_count_o) && $stable(status_o) && $stable(even_value_o) && $stable(odd_value_o), "stalled result changed")
  `BRD_ASSERT_NEXT(a_one_byte, in_valid_i && !in_stall_o, in_stall_o, "second byte taken before first finished")
  `BRD_ASSERT(a_span_nonzero, (out_valid_o && (status_o == brd_pkg::STAT_SPAN)) |-> (pixel_count_o != 8'd0), "span transfer with zero pixels")
  `BRD_ASSERT(a_flag_zero, (out_valid_o && (status_o != brd_pkg::STAT_SPAN)) |-> ((write_address_o == 24'd0) && (pixel_count_o == 8'd0) && (even_value_o == 8'd0) && (odd_value_o == 8'd0)), "flag transfer carries span data")
  `BRD_ASSERT(a_single_odd, (out_valid_o && (status_o == brd_pkg::STAT_SPAN) && (pixel_count_o == 8'd1)) |-> (odd_value_o == 8'd0), "single pixel span with odd value")

endmodule

bind bitmap_rle_decoder_top brd_checker u_checker (.*);
